[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// concurrent property wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OGH_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
`define OGH_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`else
`define OGH_ASSERT_IMP(label, clk, rst_n, lhs, rhs)
`define OGH_ASSERT_NXT(label, clk, rst_n, lhs, rhs)
`endif
`endif

[design/ogh_pkg.sv]
// ----------------------------------------------------------------------------
// ogh_pkg
// shared types and constants of the occupancy grid hit counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ogh_pkg;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 48;
    localparam int QUEUE_DEPTH = 4;
    localparam int DIST_W      = 50;

    // 20 m in Q16.16
    localparam logic signed [31:0] Z_CUT = 32'sd1310720;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GROUND_NORMAL  = 3'd0,
        CFG_GROUND_OFFSET  = 3'd1,
        CFG_GROUND_LIMIT   = 3'd2,
        CFG_RAMP_NORMAL    = 3'd3,
        CFG_RAMP_OFFSET    = 3'd4,
        CFG_RAMP_LIMIT     = 3'd5,
        CFG_RAMP_EXCLUSION = 3'd6
    } t_cfg_idx;

endpackage

`default_nettype wire

[design/ogh_ram.sv]
// ----------------------------------------------------------------------------
// ogh_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ogh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[design/ogh_queue.sv]
// ----------------------------------------------------------------------------
// ogh_queue
// small fifo between the classify front and the counter back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ogh_queue
    import ogh_pkg::*;
#(
    parameter int WIDTH = 17
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_ready,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_slot [QUEUE_DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_push, w_pop;

    assign o_ready = (r_count != CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wptr  = w_push ? PW'(r_wptr + 1'b1) : r_wptr;
        n_rptr  = w_pop  ? PW'(r_rptr + 1'b1) : r_rptr;
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = CW'(r_count + 1'b1);
        end else if (w_pop && !w_push) begin
            n_count = CW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (w_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

[design/ogh_front.sv]
// ----------------------------------------------------------------------------
// ogh_front
// point intake: depth and cell range filter, plane distances, obstacle class
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ogh_front
    import ogh_pkg::*;
#(
    parameter int GRID_SIDE = 256
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]                     i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]                    i_cfg_data,
    input  wire logic                                     i_in_valid,
    output logic                                          o_in_ready,
    input  wire logic [31:0]                              i_point_x,
    input  wire logic [31:0]                              i_point_y,
    input  wire logic [31:0]                              i_point_z,
    input  wire logic [7:0]                               i_cell_col,
    input  wire logic [7:0]                               i_cell_row,
    input  wire logic                                     i_marked,
    input  wire logic                                     i_robot_low,
    input  wire logic                                     i_clearing,
    output logic                                          o_push,
    output logic [$clog2(GRID_SIDE*GRID_SIDE):0]          o_push_data,
    input  wire logic                                     i_push_ready
);

    localparam int AW = $clog2(GRID_SIDE * GRID_SIDE);
    localparam logic [12:0] SIDE = 13'(GRID_SIDE);

    // configuration
    logic [47:0] r_gn, r_rn;
    logic [31:0] r_go, r_gl, r_ro, r_rl;
    logic        r_rex;

    // stage a: products
    logic               r_a_valid, r_a_marked, r_a_low;
    logic [AW-1:0]      r_a_addr;
    logic signed [47:0] r_pg0, r_pg1, r_pg2, r_pr0, r_pr1, r_pr2;

    // stage b: distances
    logic               r_b_valid, r_b_marked, r_b_low;
    logic [AW-1:0]      r_b_addr;
    logic [DIST_W-1:0]  r_b_gd, r_b_rd;

    logic                     w_adv, w_accept, w_keep, w_obst;
    logic signed [DIST_W-1:0] w_gs, w_rs;
    logic [DIST_W-1:0]        w_glim, w_rlim;

    assign w_adv      = !r_b_valid || i_push_ready;
    assign o_in_ready = w_adv && !i_clearing;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_keep     = w_accept && ($signed(i_point_z) < Z_CUT)
                        && (13'(i_cell_col) < SIDE) && (13'(i_cell_row) < SIDE);

    always_comb begin
        w_gs = DIST_W'(r_pg0) + DIST_W'(r_pg1) + DIST_W'(r_pg2)
               + (DIST_W'($signed(r_go)) <<< 14);
        w_rs = DIST_W'(r_pr0) + DIST_W'(r_pr1) + DIST_W'(r_pr2)
               + (DIST_W'($signed(r_ro)) <<< 14);
    end

    assign w_glim = DIST_W'({r_gl, 14'b0});
    assign w_rlim = DIST_W'({r_rl, 14'b0});
    assign w_obst = r_b_marked || (r_b_low && (r_b_gd >= w_glim)
                    && (!r_rex || (r_b_rd > w_rlim)));

    assign o_push      = r_b_valid;
    assign o_push_data = {r_b_addr, w_obst};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gn      <= '0;
            r_go      <= '0;
            r_gl      <= '0;
            r_rn      <= '0;
            r_ro      <= '0;
            r_rl      <= '0;
            r_rex     <= 1'b0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_GROUND_NORMAL:  r_gn  <= i_cfg_data;
                    CFG_GROUND_OFFSET:  r_go  <= i_cfg_data[31:0];
                    CFG_GROUND_LIMIT:   r_gl  <= i_cfg_data[31:0];
                    CFG_RAMP_NORMAL:    r_rn  <= i_cfg_data;
                    CFG_RAMP_OFFSET:    r_ro  <= i_cfg_data[31:0];
                    CFG_RAMP_LIMIT:     r_rl  <= i_cfg_data[31:0];
                    CFG_RAMP_EXCLUSION: r_rex <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_adv) begin
                r_a_valid <= w_keep;
                r_b_valid <= r_a_valid;
            end
        end
        if (w_adv) begin
            r_a_marked <= i_marked;
            r_a_low    <= i_robot_low;
            r_a_addr   <= AW'(i_cell_col) + AW'(i_cell_row) * AW'(GRID_SIDE);
            r_pg0 <= 48'($signed(r_gn[15:0]))  * 48'($signed(i_point_x));
            r_pg1 <= 48'($signed(r_gn[31:16])) * 48'($signed(i_point_y));
            r_pg2 <= 48'($signed(r_gn[47:32])) * 48'($signed(i_point_z));
            r_pr0 <= 48'($signed(r_rn[15:0]))  * 48'($signed(i_point_x));
            r_pr1 <= 48'($signed(r_rn[31:16])) * 48'($signed(i_point_y));
            r_pr2 <= 48'($signed(r_rn[47:32])) * 48'($signed(i_point_z));
            r_b_marked <= r_a_marked;
            r_b_low    <= r_a_low;
            r_b_addr   <= r_a_addr;
            r_b_gd     <= w_gs[DIST_W-1] ? DIST_W'(-w_gs) : DIST_W'(w_gs);
            r_b_rd     <= w_rs[DIST_W-1] ? DIST_W'(-w_rs) : DIST_W'(w_rs);
        end
    end

endmodule

`default_nettype wire

[design/ogh_back.sv]
// ----------------------------------------------------------------------------
// ogh_back
// counter update: clear sweep, read-modify-write of cell counts, result word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ogh_back #(
    parameter int GRID_SIDE  = 256,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_q_valid,
    input  wire logic [$clog2(GRID_SIDE*GRID_SIDE):0]  i_q_data,
    output logic                                       o_pop,
    output logic                                       o_clearing,
    output logic                                       o_ram_we,
    output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0]     o_ram_waddr,
    output logic [2*COUNT_BITS-1:0]                    o_ram_wdata,
    output logic                                       o_ram_re,
    output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0]     o_ram_raddr,
    input  wire logic [2*COUNT_BITS-1:0]               i_ram_rdata,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic [15:0]                                o_cell_index,
    output logic                                       o_occupied
);

    localparam int AW    = $clog2(GRID_SIDE * GRID_SIDE);
    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int OW    = COUNT_BITS + 4;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WAIT,
        S_OUT
    } t_state;

    t_state                r_state;
    logic [AW-1:0]         r_clr_addr;
    logic [AW-1:0]         r_addr;
    logic                  r_obst;
    logic [COUNT_BITS-1:0] r_hit, r_obs;
    logic [COUNT_BITS-1:0] w_hit_rd, w_obs_rd, w_hit_nx, w_obs_nx;
    logic [OW-1:0]         w_lhs, w_rhs;
    logic                  w_out_free;

    assign w_hit_rd   = i_ram_rdata[COUNT_BITS-1:0];
    assign w_obs_rd   = i_ram_rdata[2*COUNT_BITS-1:COUNT_BITS];
    assign w_out_free = !o_out_valid || i_out_ready;

    // saturated hit count freezes both counters
    always_comb begin
        w_hit_nx = w_hit_rd;
        w_obs_nx = w_obs_rd;
        if (w_hit_rd != {COUNT_BITS{1'b1}}) begin
            w_hit_nx = COUNT_BITS'(w_hit_rd + 1'b1);
            w_obs_nx = COUNT_BITS'(w_obs_rd + COUNT_BITS'(r_obst));
        end
    end

    // 10*obs >= 3*hit
    assign w_lhs = OW'({r_obs, 3'b0}) + OW'({r_obs, 1'b0});
    assign w_rhs = OW'({r_hit, 1'b0}) + OW'(r_hit);

    always_comb begin
        o_clearing  = (r_state == S_CLEAR);
        o_pop       = 1'b0;
        o_ram_re    = 1'b0;
        o_ram_raddr = i_q_data[AW:1];
        o_ram_we    = 1'b0;
        o_ram_waddr = r_addr;
        o_ram_wdata = {w_obs_nx, w_hit_nx};
        unique case (r_state)
            S_CLEAR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_clr_addr;
                o_ram_wdata = '0;
            end
            S_IDLE: begin
                o_pop    = i_q_valid;
                o_ram_re = i_q_valid;
            end
            S_WAIT: begin
                o_ram_we = 1'b1;
            end
            S_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_out_ready && r_state != S_OUT) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= AW'(r_clr_addr + 1'b1);
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_addr  <= i_q_data[AW:1];
                        r_obst  <= i_q_data[0];
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_hit   <= w_hit_nx;
                    r_obs   <= w_obs_nx;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        o_out_valid  <= 1'b1;
                        o_cell_index <= 16'(r_addr);
                        o_occupied   <= (w_lhs >= w_rhs);
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

[design/occupancy_grid_hit_counter_top.sv]
// ----------------------------------------------------------------------------
// occupancy_grid_hit_counter_top
// per-cell hit and obstacle counting of depth points with occupied flag
// ----------------------------------------------------------------------------
// The front takes one point per cycle unless the queue holds it back or the
// clear sweep runs, drops points at 20 m depth or beyond and points outside
// the grid, and classifies the rest over two pipeline stages (plane products,
// then distances). A four-word queue feeds the back, which does one
// read-modify-write of the cell's count memory per point, in order: queue pop
// with memory read, update write, result register. It pops the next point only
// once the last result is registered. After reset the back sweeps the count
// memory to zero, and no point is taken during the sweep; configuration writes
// are taken at any time.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module occupancy_grid_hit_counter_top
    import ogh_pkg::*;
#(
    parameter int GRID_SIDE  = 256,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [31:0]           i_point_x,
    input  wire logic [31:0]           i_point_y,
    input  wire logic [31:0]           i_point_z,
    input  wire logic [7:0]            i_cell_col,
    input  wire logic [7:0]            i_cell_row,
    input  wire logic                  i_marked,
    input  wire logic                  i_robot_low,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [15:0]                o_cell_index,
    output logic                       o_occupied
);

    localparam int AW    = $clog2(GRID_SIDE * GRID_SIDE);
    localparam int DEPTH = GRID_SIDE * GRID_SIDE;

    logic                    w_clearing;
    logic                    w_push, w_push_ready, w_q_valid, w_pop;
    logic [AW:0]             w_push_data, w_q_data;
    logic                    w_ram_we, w_ram_re;
    logic [AW-1:0]           w_ram_waddr, w_ram_raddr;
    logic [2*COUNT_BITS-1:0] w_ram_wdata, w_ram_rdata;

    assign o_cfg_ready = 1'b1;

    ogh_front #(
        .GRID_SIDE (GRID_SIDE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_point_z    (i_point_z),
        .i_cell_col   (i_cell_col),
        .i_cell_row   (i_cell_row),
        .i_marked     (i_marked),
        .i_robot_low  (i_robot_low),
        .i_clearing   (w_clearing),
        .o_push       (w_push),
        .o_push_data  (w_push_data),
        .i_push_ready (w_push_ready)
    );

    ogh_queue #(
        .WIDTH (AW + 1)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_ready (w_push_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    ogh_back #(
        .GRID_SIDE  (GRID_SIDE),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_data     (w_q_data),
        .o_pop        (w_pop),
        .o_clearing   (w_clearing),
        .o_ram_we     (w_ram_we),
        .o_ram_waddr  (w_ram_waddr),
        .o_ram_wdata  (w_ram_wdata),
        .o_ram_re     (w_ram_re),
        .o_ram_raddr  (w_ram_raddr),
        .i_ram_rdata  (w_ram_rdata),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cell_index (o_cell_index),
        .o_occupied   (o_occupied)
    );

    ogh_ram #(
        .WIDTH (2 * COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // no points in and no results out during the clear sweep
    `OGH_ASSERT_IMP(a_clear_quiet, i_clk, i_rst_n, w_clearing, !o_in_ready && !o_out_valid)
    // read and write of the same cell never overlap
    `OGH_ASSERT_IMP(a_no_rw_clash, i_clk, i_rst_n, w_ram_we && w_ram_re, w_ram_waddr != w_ram_raddr)
    // every queue pop is followed by the count write back
    `OGH_ASSERT_NXT(a_pop_writes, i_clk, i_rst_n, w_pop, w_ram_we && !w_ram_re)

endmodule

`default_nettype wire

[test/tb_occupancy_grid_hit_counter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_occupancy_grid_hit_counter_top
// self-checking bench for the occupancy grid hit counter
// ----------------------------------------------------------------------------
// Depth points go in over a valid/ready channel and cell updates come back on
// another. A built-in predictor keeps its own hit and obstacle tallies per
// cell and its own copy of the plane registers, and works out the cell index
// and occupied flag of every accepted point. Results are checked in order.
// The run has a short directed table (depth cut, grid corners, exact ground
// and ramp limits, mask priority, the 30 percent boundary), a burst of points
// on one cell, then random phases under extreme and random plane
// settings, with random gaps on both sides and a long output stall.
// ----------------------------------------------------------------------------
module tb_occupancy_grid_hit_counter_top;
    import ogh_pkg::*;

    localparam int GRID_SIDE    = 256;
    localparam int COUNT_BITS   = 16;
    localparam int SETTLE       = 32;
    localparam int LONG_HOLD    = 300;
    localparam int BURST_POINTS = 200;
    localparam int PHASE_ITEMS  = 80;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam bit [COUNT_BITS-1:0] COUNT_TOP = '1;

    typedef struct packed {
        bit [31:0] x;
        bit [31:0] y;
        bit [31:0] z;
        bit [7:0]  col;
        bit [7:0]  row;
        bit        marked;
        bit        low;
    } point_t;

    typedef struct packed {
        bit [15:0] cell_index;
        bit        occupied;
    } cell_update_t;

    typedef struct packed {
        bit [47:0] gnd_n;
        bit [31:0] gnd_off;
        bit [31:0] gnd_lim;
        bit [47:0] rmp_n;
        bit [31:0] rmp_off;
        bit [31:0] rmp_lim;
        bit        excl;
    } plane_set_t;

    typedef struct packed {
        point_t       pt;
        bit           typed;
        cell_update_t want;
    } stim_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [31:0]           i_point_x = '0;
    logic [31:0]           i_point_y = '0;
    logic [31:0]           i_point_z = '0;
    logic [7:0]            i_cell_col = '0;
    logic [7:0]            i_cell_row = '0;
    logic                  i_marked = 1'b0;
    logic                  i_robot_low = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [15:0]           o_cell_index;
    logic                  o_occupied;

    occupancy_grid_hit_counter_top #(
        .GRID_SIDE (GRID_SIDE),
        .COUNT_BITS(COUNT_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .i_point_z   (i_point_z),
        .i_cell_col  (i_cell_col),
        .i_cell_row  (i_cell_row),
        .i_marked    (i_marked),
        .i_robot_low (i_robot_low),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cell_index(o_cell_index),
        .o_occupied  (o_occupied)
    );

    always #5 i_clk = ~i_clk;

    bit [COUNT_BITS-1:0] cell_hits      [GRID_SIDE*GRID_SIDE];
    bit [COUNT_BITS-1:0] cell_obstacles [GRID_SIDE*GRID_SIDE];
    plane_set_t          plane_cfg;
    cell_update_t        cell_updates_due[$];
    stim_row_t           directed_rows[$];

    bit           row_typed;
    cell_update_t row_want;
    bit           send_gaps;
    bit           ready_gaps;
    bit           hold_out_request;
    int           mismatches;

    function automatic longint unsigned plane_gap(bit [47:0] nrm, bit [31:0] off,
                                                  longint px, longint py, longint pz);
        longint a, b, c, d, s;
        a = $signed(nrm[15:0]);
        b = $signed(nrm[31:16]);
        c = $signed(nrm[47:32]);
        d = $signed(off);
        s = a * px + b * py + c * pz + d * 64'sd16384;
        return (s < 0) ? -s : s;
    endfunction

    // updates the tallies; returns 0 when the point gives no cell update
    function automatic bit classify_point(point_t p, output cell_update_t upd);
        longint px, py, pz;
        longint unsigned gd, rd;
        bit obstacle;
        bit [15:0] n;
        upd = '0;
        if ($signed(p.z) >= Z_CUT)
            return 1'b0;
        px = $signed(p.x);
        py = $signed(p.y);
        pz = $signed(p.z);
        n = {p.row, p.col};
        obstacle = 1'b0;
        if (p.marked) begin
            obstacle = 1'b1;
        end else if (p.low) begin
            gd = plane_gap(plane_cfg.gnd_n, plane_cfg.gnd_off, px, py, pz);
            if (gd >= (64'(plane_cfg.gnd_lim) << 14)) begin
                if (plane_cfg.excl) begin
                    rd = plane_gap(plane_cfg.rmp_n, plane_cfg.rmp_off, px, py, pz);
                    obstacle = !(rd <= (64'(plane_cfg.rmp_lim) << 14));
                end else begin
                    obstacle = 1'b1;
                end
            end
        end
        if (cell_hits[n] != COUNT_TOP) begin
            cell_hits[n]++;
            if (obstacle)
                cell_obstacles[n]++;
        end
        upd.cell_index = n;
        upd.occupied = (10 * int'(cell_obstacles[n]) >= 3 * int'(cell_hits[n]));
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        cell_update_t upd;
        cell_update_t due;
        point_t p;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_GROUND_NORMAL:  plane_cfg.gnd_n   = i_cfg_data[47:0];
                    CFG_GROUND_OFFSET:  plane_cfg.gnd_off = i_cfg_data[31:0];
                    CFG_GROUND_LIMIT:   plane_cfg.gnd_lim = i_cfg_data[31:0];
                    CFG_RAMP_NORMAL:    plane_cfg.rmp_n   = i_cfg_data[47:0];
                    CFG_RAMP_OFFSET:    plane_cfg.rmp_off = i_cfg_data[31:0];
                    CFG_RAMP_LIMIT:     plane_cfg.rmp_lim = i_cfg_data[31:0];
                    CFG_RAMP_EXCLUSION: plane_cfg.excl    = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (o_out_valid && i_out_ready) begin
                if (cell_updates_due.size() == 0) begin
                    mismatches++;
                    $error("unexpected word: cell_index %0d occupied %0b",
                           o_cell_index, o_occupied);
                end else begin
                    due = cell_updates_due.pop_front();
                    if (o_cell_index !== due.cell_index) begin
                        mismatches++;
                        $error("cell_index: expected %0d, got %0d",
                               due.cell_index, o_cell_index);
                    end
                    if (o_occupied !== due.occupied) begin
                        mismatches++;
                        $error("occupied: expected %0b, got %0b",
                               due.occupied, o_occupied);
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                p = '{i_point_x, i_point_y, i_point_z, i_cell_col, i_cell_row,
                      i_marked, i_robot_low};
                if (classify_point(p, upd)) begin
                    if (row_typed)
                        upd = row_want;
                    cell_updates_due.insert(cell_updates_due.size(), upd);
                end
            end
        end
    end

    // output side
    initial begin
        int stall;
        forever begin
            if (hold_out_request) begin
                stall = LONG_HOLD;
                hold_out_request = 1'b0;
            end else begin
                stall = ready_gaps ? $urandom_range(0, 19) : 0;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    task automatic send_point(point_t p, bit typed, cell_update_t want);
        int gap;
        gap = send_gaps ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_point_x   <= p.x;
        i_point_y   <= p.y;
        i_point_z   <= p.z;
        i_cell_col  <= p.col;
        i_cell_row  <= p.row;
        i_marked    <= p.marked;
        i_robot_low <= p.low;
        row_typed   <= typed;
        row_want    <= want;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
    endtask

    // unused upper data bits carry junk
    task automatic load_planes(plane_set_t s);
        cfg_write(CFG_GROUND_NORMAL, s.gnd_n);
        cfg_write(CFG_GROUND_OFFSET, {16'($urandom()), s.gnd_off});
        cfg_write(CFG_GROUND_LIMIT, {16'($urandom()), s.gnd_lim});
        cfg_write(CFG_RAMP_NORMAL, s.rmp_n);
        cfg_write(CFG_RAMP_OFFSET, {16'($urandom()), s.rmp_off});
        cfg_write(CFG_RAMP_LIMIT, {16'($urandom()), s.rmp_lim});
        cfg_write(CFG_RAMP_EXCLUSION, {47'($urandom()), s.excl});
    endtask

    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (cell_updates_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic void add_row(bit [31:0] x, bit [31:0] y, bit [31:0] z,
                                    bit [7:0] col, bit [7:0] row, bit marked, bit low,
                                    bit typed = 1'b0, bit occ = 1'b0);
        stim_row_t r;
        r.pt    = '{x, y, z, col, row, marked, low};
        r.typed = typed;
        r.want  = '{{row, col}, occ};
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    function automatic bit [31:0] near_coord();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        return $urandom();
    endfunction

    function automatic point_t rand_point();
        point_t p;
        p.x = near_coord();
        p.y = near_coord();
        if ($urandom_range(0, 99) < 85)
            p.z = $urandom_range(0, 26 * 65536) - 4 * 65536;
        else
            p.z = $urandom();
        if ($urandom_range(0, 99) < 70) begin
            p.col = 8'h20 + 8'($urandom_range(0, 3));
            p.row = 8'h10 + 8'($urandom_range(0, 3));
        end else begin
            p.col = 8'($urandom_range(0, 255));
            p.row = 8'($urandom_range(0, 255));
        end
        p.marked = ($urandom_range(0, 3) == 0);
        p.low    = 1'($urandom_range(0, 1));
        return p;
    endfunction

    function automatic plane_set_t phase_planes(int ph);
        plane_set_t s;
        case (ph)
            0: s = '0;
            1: s = '{{3{16'h7FFF}}, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                     {3{16'h7FFF}}, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1};
            2: s = '{{3{16'h8000}}, 32'h8000_0000, 32'h0000_0000,
                     {3{16'h8000}}, 32'h8000_0000, 32'h0000_0000, 1'b1};
            default: begin
                s.gnd_n   = {16'($urandom()), 32'($urandom())};
                s.gnd_off = $urandom_range(0, 8 * 65536) - 4 * 65536;
                s.gnd_lim = $urandom_range(0, 2 * 65536);
                s.rmp_n   = {16'($urandom()), 32'($urandom())};
                s.rmp_off = $urandom_range(0, 8 * 65536) - 4 * 65536;
                s.rmp_lim = $urandom_range(0, 2 * 65536);
                s.excl    = (ph != 5);
            end
        endcase
        return s;
    endfunction

    initial begin
        #20_000_000;
        $display("tb_occupancy_grid_hit_counter_top NOT OK");
        $finish;
    end

    initial begin
        plane_set_t   s;
        point_t       p;
        cell_update_t none;
        none = '0;
        send_gaps  = 1'b1;
        ready_gaps = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ground plane y = 1 m, limit 0.5 m; ramp plane y = 2 m, limit 0.25 m
        s = '{48'h0000_4000_0000, 32'hFFFF_0000, 32'h0000_8000,
              48'h0000_4000_0000, 32'hFFFE_0000, 32'h0000_4000, 1'b1};
        load_planes(s);
        cfg_write(CFG_SPARE, '1);
        i_cfg_valid <= 1'b0;

        add_row(32'h0, 32'h0, 32'h0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b1, 1'b1);
        add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 8'd255, 8'd255, 1'b0, 1'b0,
                1'b1, 1'b0);
        add_row(32'h0, 32'h0, Z_CUT, 8'd1, 8'd0, 1'b1, 1'b1);
        add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd1, 8'd0, 1'b1, 1'b1);
        add_row(32'h0, 32'h0, 32'h0013_FFFF, 8'd1, 8'd0, 1'b0, 1'b0, 1'b1, 1'b0);
        add_row(32'h0, 32'h0, 32'h8000_0000, 8'd2, 8'd0, 1'b0, 1'b1);
        // exactly at and just inside the ground limit
        add_row(32'h0, 32'h0001_8000, 32'h0002_0000, 8'd3, 8'd0, 1'b0, 1'b1);
        add_row(32'h0, 32'h0001_7FFF, 32'h0002_0000, 8'd4, 8'd0, 1'b0, 1'b1);
        // exactly at and just outside the ramp limit
        add_row(32'h0, 32'h0001_C000, 32'h0002_0000, 8'd5, 8'd0, 1'b0, 1'b1);
        add_row(32'h0, 32'h0001_BFFF, 32'h0002_0000, 8'd6, 8'd0, 1'b0, 1'b1);
        add_row(32'h0, 32'h0002_0000, 32'h0002_0000, 8'd7, 8'd0, 1'b0, 1'b1);
        add_row(32'h0, 32'h0002_0000, 32'h0002_0000, 8'd8, 8'd0, 1'b1, 1'b1,
                1'b1, 1'b1);
        add_row(32'h0, 32'h0001_C000, 32'h0002_0000, 8'd5, 8'd0, 1'b0, 1'b0);
        // obstacle share falls through 30 percent
        add_row(32'h0, 32'h0, 32'h0001_0000, 8'd9, 8'd1, 1'b1, 1'b0, 1'b1, 1'b1);
        add_row(32'h0, 32'h0, 32'h0001_0000, 8'd9, 8'd1, 1'b0, 1'b0);
        add_row(32'h0, 32'h0, 32'h0001_0000, 8'd9, 8'd1, 1'b0, 1'b0);
        add_row(32'h0, 32'h0, 32'h0001_0000, 8'd9, 8'd1, 1'b0, 1'b0);
        add_row(32'h0, 32'h0, 32'h0001_0000, 8'd9, 8'd1, 1'b0, 1'b0);
        add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 8'd10, 8'd200, 1'b0, 1'b1);
        add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd254, 8'd1, 1'b0, 1'b1);

        foreach (directed_rows[i])
            send_point(directed_rows[i].pt, directed_rows[i].typed, directed_rows[i].want);
        settle_block();

        // back to back points on one cell
        send_gaps  = 1'b0;
        ready_gaps = 1'b0;
        for (int i = 0; i < BURST_POINTS; i++) begin
            p = rand_point();
            p.z = $urandom_range(0, 19 * 65536);
            p.col = 8'd77;
            p.row = 8'd3;
            p.marked = ($urandom_range(0, 9) < 3);
            send_point(p, 1'b0, none);
        end
        settle_block();

        for (int ph = 0; ph < 6; ph++) begin
            load_planes(phase_planes(ph));
            i_cfg_valid <= 1'b0;
            send_gaps  = (ph != 4);
            ready_gaps = (ph != 4);
            if (ph == 3) begin
                hold_out_request = 1'b1;
                send_gaps = 1'b0;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (ph == 3 && i == 40)
                    send_gaps = 1'b1;
                send_point(rand_point(), 1'b0, none);
            end
            settle_block();
        end

        if (mismatches == 0 && cell_updates_due.size() == 0)
            $display("tb_occupancy_grid_hit_counter_top OK");
        else
            $display("tb_occupancy_grid_hit_counter_top NOT OK");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/ogh_pkg.sv
design/ogh_ram.sv
design/ogh_queue.sv
design/ogh_front.sv
design/ogh_back.sv
design/occupancy_grid_hit_counter_top.sv
test/tb_occupancy_grid_hit_counter_top.sv
